@@ design/cpu8_register_stack_incdec_unit_assert.svh @@
// Assertion macros for the register/stack/inc-dec unit checker.
// Used by c8rs_checker; expects i_clk and i_rst_n in scope.
`ifndef CPU8_REGISTER_STACK_INCDEC_UNIT_ASSERT_SVH
`define CPU8_REGISTER_STACK_INCDEC_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define C8RS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("c8rs check failed");

// next-cycle implication, off during reset
`define C8RS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("c8rs check failed");

`endif

@@ design/c8rs_pkg.sv @@
// Shared types, constants and helpers for the register/stack/inc-dec unit.
// No dependencies.
package c8rs_pkg;

    localparam int C8RS_MAX_CYC = 6;
    localparam int C8RS_CNT_W   = $clog2(C8RS_MAX_CYC + 1);

    localparam logic [7:0]  FLAG_B      = 8'h10;
    localparam logic [7:0]  FLAG_U      = 8'h20;
    localparam logic [7:0]  STACK_PAGE  = 8'h01;
    localparam logic [7:0]  ZERO_PAGE   = 8'h00;
    localparam logic [7:0]  SP_RESET    = 8'hFD;
    localparam logic [7:0]  P_RESET     = 8'h20;
    localparam logic [4:0]  KIND_RMW_LO = 5'd14;
    localparam logic [4:0]  KIND_DEC_LO = 5'd18;

    typedef enum logic [4:0] {
        K_TAX      = 5'd0,
        K_TAY      = 5'd1,
        K_TXA      = 5'd2,
        K_TYA      = 5'd3,
        K_TSX      = 5'd4,
        K_TXS      = 5'd5,
        K_PHA      = 5'd6,
        K_PLA      = 5'd7,
        K_PHP      = 5'd8,
        K_PLP      = 5'd9,
        K_INX      = 5'd10,
        K_INY      = 5'd11,
        K_DEX      = 5'd12,
        K_DEY      = 5'd13,
        K_INC_ZP   = 5'd14,
        K_INC_ZPX  = 5'd15,
        K_INC_ABS  = 5'd16,
        K_INC_ABSX = 5'd17,
        K_DEC_ZP   = 5'd18,
        K_DEC_ZPX  = 5'd19,
        K_DEC_ABS  = 5'd20,
        K_DEC_ABSX = 5'd21
    } t_kind;

    typedef enum logic [1:0] {
        M_ZP   = 2'd0,
        M_ZPX  = 2'd1,
        M_ABS  = 2'd2,
        M_ABSX = 2'd3
    } t_mode;

    typedef struct packed {
        logic [15:0] addr;
        logic        wr;
        logic [7:0]  data;
        logic        dummy;
    } t_bus_cycle;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [7:0]  p;
        logic [15:0] pc;
    } t_regs;

    function automatic t_bus_cycle mk_cyc(logic [15:0] addr, logic wr, logic [7:0] data,
                                          logic dummy);
        t_bus_cycle c;
        c.addr  = addr;
        c.wr    = wr;
        c.data  = data;
        c.dummy = dummy;
        return c;
    endfunction

    function automatic logic [7:0] set_nz(logic [7:0] p, logic [7:0] v);
        return {v[7], p[6:2], (v == 8'h00), p[0]};
    endfunction

endpackage

@@ design/c8rs_if.sv @@
// Valid/ready channel interfaces for the register/stack/inc-dec unit.
// Depends on nothing; payload fields as the unit's item and result.
interface c8rs_in_if;
    logic       valid;
    logic       ready;
    logic [4:0] kind;
    logic [7:0] operand_lo;
    logic [7:0] operand_hi;
    logic [7:0] mem_value;

    modport source (output valid, kind, operand_lo, operand_hi, mem_value, input ready);
    modport sink   (input valid, kind, operand_lo, operand_hi, mem_value, output ready);
endinterface

interface c8rs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] bus_address;
    logic        bus_write;
    logic [7:0]  bus_data;
    logic        is_dummy;
    logic        last;
    logic [7:0]  reg_a;
    logic [7:0]  reg_x;
    logic [7:0]  reg_y;
    logic [7:0]  reg_sp;
    logic [7:0]  reg_status;

    modport source (output valid, bus_address, bus_write, bus_data, is_dummy, last,
                    reg_a, reg_x, reg_y, reg_sp, reg_status, input ready);
    modport sink   (input valid, bus_address, bus_write, bus_data, is_dummy, last,
                    reg_a, reg_x, reg_y, reg_sp, reg_status, output ready);
endinterface

@@ design/cpu8_register_stack_incdec_unit.sv @@
// Top level of the register/stack/inc-dec execution unit.
// Depends on c8rs_pkg, c8rs_if and c8rs_exec.
//
// Usage:
//   i_in carries one instruction per transaction (kind, operand bytes and
//   the memory byte). o_out carries one transaction per bus cycle of that
//   instruction, with last set on the final one and the register file as it
//   stands after the instruction.
//   An accepted instruction is evaluated in the accepting cycle; its bus
//   cycles are loaded into a six-entry result shift line and the first one
//   is presented in the next cycle. Each instruction then gives 1 to 6
//   transactions on o_out, one per bus cycle: 1 for transfers and index
//   inc/dec, 2 for pushes, 3 for pulls, 4 to 6 for memory inc/dec. The
//   output drain of one result per cycle, while o_out.ready is high, sets
//   the rate; i_in.ready is high when the line is empty or its last entry
//   is being taken, so the next instruction follows without a gap.
//   Kinds 22 to 31 are accepted and produce no transaction.
//   Reset clears the line and loads A, X, Y = 0, SP = 0xFD, P = 0x20,
//   PC = 0. While o_out is stalled the current transaction holds and no new
//   instruction is taken once the last entry is waiting.
module cpu8_register_stack_incdec_unit
    import c8rs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    c8rs_in_if.sink     i_in,
    c8rs_out_if.source  o_out
);
    t_regs                          r_regs;
    t_regs                          n_regs;
    t_bus_cycle [C8RS_MAX_CYC-1:0]  r_buf;
    t_bus_cycle [C8RS_MAX_CYC-1:0]  n_buf;
    logic [C8RS_CNT_W-1:0]          r_cnt;
    logic [C8RS_CNT_W-1:0]          n_cnt;
    logic                           in_fire;
    logic                           out_fire;

    c8rs_exec u_exec (
        .i_kind       (i_in.kind),
        .i_operand_lo (i_in.operand_lo),
        .i_operand_hi (i_in.operand_hi),
        .i_mem_value  (i_in.mem_value),
        .i_regs       (r_regs),
        .o_regs       (n_regs),
        .o_cycles     (n_buf),
        .o_count      (n_cnt)
    );

    assign out_fire   = o_out.valid && o_out.ready;
    assign i_in.ready = (r_cnt == '0) || (o_out.ready && (r_cnt == C8RS_CNT_W'(1)));
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.a  <= 8'h00;
            r_regs.x  <= 8'h00;
            r_regs.y  <= 8'h00;
            r_regs.sp <= SP_RESET;
            r_regs.p  <= P_RESET;
            r_regs.pc <= 16'h0000;
            r_cnt     <= '0;
        end else if (in_fire) begin
            r_regs <= n_regs;
            r_cnt  <= n_cnt;
        end else if (out_fire) begin
            r_cnt <= r_cnt - C8RS_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_buf <= n_buf;
        end else if (out_fire) begin
            for (int k = 0; k < C8RS_MAX_CYC - 1; k++) begin
                r_buf[k] <= r_buf[k+1];
            end
        end
    end

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.last        = (r_cnt == C8RS_CNT_W'(1));
    assign o_out.bus_address = r_buf[0].addr;
    assign o_out.bus_write   = r_buf[0].wr;
    assign o_out.bus_data    = r_buf[0].data;
    assign o_out.is_dummy    = r_buf[0].dummy;
    assign o_out.reg_a       = r_regs.a;
    assign o_out.reg_x       = r_regs.x;
    assign o_out.reg_y       = r_regs.y;
    assign o_out.reg_sp      = r_regs.sp;
    assign o_out.reg_status  = r_regs.p;
endmodule

@@ design/c8rs_exec.sv @@
// Instruction evaluation: next register file and the full bus cycle list.
// Depends on c8rs_pkg.
module c8rs_exec
    import c8rs_pkg::*;
(
    input  logic [4:0]                           i_kind,
    input  logic [7:0]                           i_operand_lo,
    input  logic [7:0]                           i_operand_hi,
    input  logic [7:0]                           i_mem_value,
    input  t_regs                                i_regs,
    output t_regs                                o_regs,
    output t_bus_cycle [C8RS_MAX_CYC-1:0]        o_cycles,
    output logic [C8RS_CNT_W-1:0]                o_count
);
    logic [15:0] stk_addr;
    logic [15:0] stk_addr_inc;
    logic [7:0]  lo_plus_x;
    logic [15:0] rmw_addr;
    logic [7:0]  rmw_new;
    logic [2:0]  rmw_base;
    t_mode       mode;
    logic        is_dec;

    assign stk_addr     = {STACK_PAGE, i_regs.sp};
    assign stk_addr_inc = {STACK_PAGE, i_regs.sp + 8'd1};
    assign lo_plus_x    = i_operand_lo + i_regs.x;
    assign mode         = t_mode'(2'(i_kind - KIND_RMW_LO));
    assign is_dec       = (i_kind >= KIND_DEC_LO);
    assign rmw_new      = is_dec ? i_mem_value - 8'd1 : i_mem_value + 8'd1;

    always_comb begin
        o_regs   = i_regs;
        o_cycles = '0;
        o_count  = '0;
        rmw_addr = {ZERO_PAGE, i_operand_lo};
        rmw_base = 3'd1;
        o_cycles[0] = mk_cyc(i_regs.pc, 1'b0, 8'h00, 1'b1);
        case (t_kind'(i_kind))
            K_TAX: begin
                o_regs.x = i_regs.a;
                o_regs.p = set_nz(i_regs.p, i_regs.a);
                o_count  = C8RS_CNT_W'(1);
            end
            K_TAY: begin
                o_regs.y = i_regs.a;
                o_regs.p = set_nz(i_regs.p, i_regs.a);
                o_count  = C8RS_CNT_W'(1);
            end
            K_TXA: begin
                o_regs.a = i_regs.x;
                o_regs.p = set_nz(i_regs.p, i_regs.x);
                o_count  = C8RS_CNT_W'(1);
            end
            K_TYA: begin
                o_regs.a = i_regs.y;
                o_regs.p = set_nz(i_regs.p, i_regs.y);
                o_count  = C8RS_CNT_W'(1);
            end
            K_TSX: begin
                o_regs.x = i_regs.sp;
                o_regs.p = set_nz(i_regs.p, i_regs.sp);
                o_count  = C8RS_CNT_W'(1);
            end
            K_TXS: begin
                o_regs.sp = i_regs.x;
                o_count   = C8RS_CNT_W'(1);
            end
            K_PHA: begin
                o_cycles[1] = mk_cyc(stk_addr, 1'b1, i_regs.a, 1'b0);
                o_regs.sp   = i_regs.sp - 8'd1;
                o_count     = C8RS_CNT_W'(2);
            end
            K_PHP: begin
                o_cycles[1] = mk_cyc(stk_addr, 1'b1, i_regs.p | FLAG_B | FLAG_U, 1'b0);
                o_regs.sp   = i_regs.sp - 8'd1;
                o_count     = C8RS_CNT_W'(2);
            end
            K_PLA: begin
                o_cycles[1] = mk_cyc(stk_addr, 1'b0, 8'h00, 1'b1);
                o_cycles[2] = mk_cyc(stk_addr_inc, 1'b0, i_mem_value, 1'b0);
                o_regs.sp   = i_regs.sp + 8'd1;
                o_regs.a    = i_mem_value;
                o_regs.p    = set_nz(i_regs.p, i_mem_value);
                o_count     = C8RS_CNT_W'(3);
            end
            K_PLP: begin
                o_cycles[1] = mk_cyc(stk_addr, 1'b0, 8'h00, 1'b1);
                o_cycles[2] = mk_cyc(stk_addr_inc, 1'b0, i_mem_value, 1'b0);
                o_regs.sp   = i_regs.sp + 8'd1;
                o_regs.p    = i_mem_value | FLAG_U;
                o_count     = C8RS_CNT_W'(3);
            end
            K_INX: begin
                o_regs.x = i_regs.x + 8'd1;
                o_regs.p = set_nz(i_regs.p, o_regs.x);
                o_count  = C8RS_CNT_W'(1);
            end
            K_INY: begin
                o_regs.y = i_regs.y + 8'd1;
                o_regs.p = set_nz(i_regs.p, o_regs.y);
                o_count  = C8RS_CNT_W'(1);
            end
            K_DEX: begin
                o_regs.x = i_regs.x - 8'd1;
                o_regs.p = set_nz(i_regs.p, o_regs.x);
                o_count  = C8RS_CNT_W'(1);
            end
            K_DEY: begin
                o_regs.y = i_regs.y - 8'd1;
                o_regs.p = set_nz(i_regs.p, o_regs.y);
                o_count  = C8RS_CNT_W'(1);
            end
            K_INC_ZP, K_INC_ZPX, K_INC_ABS, K_INC_ABSX,
            K_DEC_ZP, K_DEC_ZPX, K_DEC_ABS, K_DEC_ABSX: begin
                o_cycles[0] = mk_cyc(i_regs.pc, 1'b0, i_operand_lo, 1'b0);
                o_regs.pc   = i_regs.pc + 16'd1;
                case (mode)
                    M_ZP: begin
                        rmw_addr = {ZERO_PAGE, i_operand_lo};
                        rmw_base = 3'd1;
                    end
                    M_ZPX: begin
                        o_cycles[1] = mk_cyc({ZERO_PAGE, i_operand_lo}, 1'b0, 8'h00, 1'b1);
                        rmw_addr    = {ZERO_PAGE, lo_plus_x};
                        rmw_base    = 3'd2;
                    end
                    M_ABS: begin
                        o_cycles[1] = mk_cyc(i_regs.pc + 16'd1, 1'b0, i_operand_hi, 1'b0);
                        o_regs.pc   = i_regs.pc + 16'd2;
                        rmw_addr    = {i_operand_hi, i_operand_lo};
                        rmw_base    = 3'd2;
                    end
                    M_ABSX: begin
                        o_cycles[1] = mk_cyc(i_regs.pc + 16'd1, 1'b0, i_operand_hi, 1'b0);
                        o_cycles[2] = mk_cyc({i_operand_hi, lo_plus_x}, 1'b0, 8'h00, 1'b1);
                        o_regs.pc   = i_regs.pc + 16'd2;
                        rmw_addr    = {i_operand_hi, i_operand_lo} + {8'h00, i_regs.x};
                        rmw_base    = 3'd3;
                    end
                    default: begin
                        rmw_base = 3'd1;
                    end
                endcase
                o_cycles[rmw_base]        = mk_cyc(rmw_addr, 1'b0, i_mem_value, 1'b0);
                o_cycles[rmw_base + 3'd1] = mk_cyc(rmw_addr, 1'b1, i_mem_value, 1'b1);
                o_cycles[rmw_base + 3'd2] = mk_cyc(rmw_addr, 1'b1, rmw_new, 1'b0);
                o_regs.p = set_nz(i_regs.p, rmw_new);
                o_count  = C8RS_CNT_W'(rmw_base + 3'd3);
            end
            default: begin
                o_count = '0;
            end
        endcase
    end
endmodule

@@ design/c8rs_checker.sv @@
// Port-level checks for the register/stack/inc-dec unit, bound to the top level.
// Depends on cpu8_register_stack_incdec_unit_assert.svh.
`include "cpu8_register_stack_incdec_unit_assert.svh"

module c8rs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_bus_address,
    input logic        i_out_bus_write,
    input logic        i_out_is_dummy,
    input logic        i_out_last
);
    `C8RS_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_bus_address))
    `C8RS_ASSERT_NXT(a_no_gap, i_out_valid && i_out_ready && !i_out_last, i_out_valid)
    `C8RS_ASSERT_IMP(a_take_at_end, i_in_valid && i_in_ready, !i_out_valid || (i_out_ready && i_out_last))
    `C8RS_ASSERT_IMP(a_dummy_wr_not_last, i_out_valid && i_out_bus_write && i_out_is_dummy, !i_out_last)
endmodule

bind cpu8_register_stack_incdec_unit c8rs_checker u_c8rs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_bus_address (o_out.bus_address),
    .i_out_bus_write   (o_out.bus_write),
    .i_out_is_dummy    (o_out.is_dummy),
    .i_out_last        (o_out.last)
);
